### hdl/tapa_pkg.sv
// ----------------------------------------------------------------------------
// Tensor axis permute addresser package
// Shared constants, codes, types and helpers of the axis permute addresser.
// ----------------------------------------------------------------------------
package tapa_pkg;

  localparam int unsigned ElementBitsDef = 64;
  localparam int unsigned IndexBitsDef   = 32;
  localparam int unsigned MaxRank        = 4;
  localparam int unsigned NumAxes        = 4;
  localparam int unsigned AxisBits       = 2;
  localparam int unsigned CoordBits      = 16;
  localparam int unsigned RankBits       = 3;
  localparam int unsigned OrderBits      = NumAxes * AxisBits;
  localparam int unsigned StatusBits     = 3;
  localparam int unsigned CfgIdxBits     = 3;
  localparam int unsigned CfgDataBits    = 16;

  typedef enum logic [StatusBits-1:0] {
    ST_OK         = 3'd0,
    ST_ZERO_RANK  = 3'd1,
    ST_AXIS_RANGE = 3'd2,
    ST_DUP_AXIS   = 3'd3,
    ST_TOO_MANY   = 3'd4
  } status_e;

  typedef enum logic [CfgIdxBits-1:0] {
    CFG_RANK  = 3'd0,
    CFG_SIZE0 = 3'd1,
    CFG_SIZE1 = 3'd2,
    CFG_SIZE2 = 3'd3,
    CFG_SIZE3 = 3'd4,
    CFG_ORDER = 3'd5
  } cfg_reg_e;

  typedef enum logic [2:0] {
    SU_IDLE,
    SU_CHECK,
    SU_STRIDE_MUL,
    SU_STRIDE_ACC,
    SU_SPAN_MUL,
    SU_SPAN_ADD
  } setup_state_e;

  typedef logic [NumAxes-1:0][CoordBits-1:0] size_arr_t;

  typedef struct packed {
    logic    busy;
    status_e status;
  } setup_res_t;

  // A size of zero behaves as a size of one.
  function automatic logic [CoordBits-1:0] eff_size(logic [CoordBits-1:0] s);
    return (s == '0) ? CoordBits'(1) : s;
  endfunction

  // Largest coordinate along an axis.
  function automatic logic [CoordBits-1:0] max_coord(logic [CoordBits-1:0] s);
    return (s == '0) ? '0 : s - CoordBits'(1);
  endfunction

endpackage

### hdl/tensor_axis_permute_addresser_unit.sv
// ----------------------------------------------------------------------------
// Tensor axis permute addresser
// An accepted item's result is registered and shows in the next cycle, at one
// item per cycle while setup is idle and the output is not stalled; a new item
// enters in the cycle in which the held result leaves. After a register write
// the setup sequencer checks the settings, then works out strides and steps
// axis by axis on one shared multiplier; no item is accepted meanwhile. An
// invalid axis setting stops it at the check, an element count beyond the index
// width after strides. Reset: rank 1, sizes 1, identity order, ready at once.
// ----------------------------------------------------------------------------
module tensor_axis_permute_addresser_unit #(
  parameter int unsigned ELEMENT_BITS = tapa_pkg::ElementBitsDef,
  parameter int unsigned INDEX_BITS   = tapa_pkg::IndexBitsDef
) (
  input  logic                                             clk_i,
  input  logic                                             rst_ni,
  input  logic                                             s_axis_tvalid,
  output logic                                             s_axis_tready,
  // Fields from bit 0: element_value.
  input  logic [((ELEMENT_BITS+7)/8)*8-1:0]                s_axis_tdata,
  output logic                                             m_axis_tvalid,
  input  logic                                             m_axis_tready,
  // Fields from bit 0: dest_index, moved_value.
  output logic [((INDEX_BITS+ELEMENT_BITS+7)/8)*8-1:0]     m_axis_tdata,
  output logic                                             m_axis_tlast,
  // Fields from bit 0: status.
  output logic [tapa_pkg::StatusBits-1:0]                  m_axis_tuser,
  input  logic                                             cfg_valid_i,
  output logic                                             cfg_ready_o,
  input  logic [tapa_pkg::CfgIdxBits-1:0]                  cfg_index_i,
  input  logic [tapa_pkg::CfgDataBits-1:0]                 cfg_data_i
);
  import tapa_pkg::*;

  localparam int unsigned OutDataBits = ((INDEX_BITS + ELEMENT_BITS + 7) / 8) * 8;

  logic [RankBits-1:0]                  rank_q;
  size_arr_t                            size_q;
  logic [OrderBits-1:0]                 order_q;
  logic [NumAxes-1:0][CoordBits-1:0]    coord_q, coord_d;
  logic [INDEX_BITS-1:0]                offset_q, offset_d;
  logic                                 out_valid_q;
  logic [INDEX_BITS-1:0]                dest_q;
  logic [ELEMENT_BITS-1:0]              moved_q;
  logic                                 last_q;
  logic [StatusBits-1:0]                status_q;

  setup_res_t                           setup_res;
  logic [NumAxes-1:0][INDEX_BITS-1:0]   delta;
  logic                                 cfg_hit;
  logic                                 cfg_fire;
  logic                                 in_fire;
  logic [NumAxes-1:0]                   in_use;
  logic [NumAxes-1:0]                   at_max;
  logic [NumAxes-1:0]                   carry_in;
  logic                                 is_last;
  logic [INDEX_BITS-1:0]                step;
  logic                                 cfg_ok;

  always_comb begin
    case (cfg_index_i)
      CFG_RANK, CFG_SIZE0, CFG_SIZE1, CFG_SIZE2, CFG_SIZE3, CFG_ORDER: begin
        cfg_hit = 1'b1;
      end
      default: begin
        cfg_hit = 1'b0;
      end
    endcase
  end

  assign cfg_ready_o = 1'b1;
  assign cfg_fire    = cfg_valid_i && cfg_hit;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rank_q  <= RankBits'(1);
      size_q  <= {NumAxes{CoordBits'(1)}};
      order_q <= OrderBits'(8'd228);
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_RANK:  rank_q    <= cfg_data_i[RankBits-1:0];
        CFG_SIZE0: size_q[0] <= cfg_data_i[CoordBits-1:0];
        CFG_SIZE1: size_q[1] <= cfg_data_i[CoordBits-1:0];
        CFG_SIZE2: size_q[2] <= cfg_data_i[CoordBits-1:0];
        CFG_SIZE3: size_q[3] <= cfg_data_i[CoordBits-1:0];
        CFG_ORDER: order_q   <= cfg_data_i[OrderBits-1:0];
        default: begin
        end
      endcase
    end
  end

  tapa_setup #(
    .INDEX_BITS(INDEX_BITS)
  ) u_setup (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cfg_fire),
    .rank_i  (rank_q),
    .sizes_i (size_q),
    .order_i (order_q),
    .res_o   (setup_res),
    .delta_o (delta)
  );

  assign cfg_ok        = (setup_res.status == ST_OK);
  assign s_axis_tready = !setup_res.busy && (!out_valid_q || m_axis_tready);
  assign in_fire       = s_axis_tvalid && s_axis_tready;

  always_comb begin
    logic c;
    c        = 1'b1;
    step     = '0;
    coord_d  = coord_q;
    for (int d = NumAxes - 1; d >= 0; d--) begin
      in_use[d]   = (d < int'(rank_q));
      at_max[d]   = !in_use[d] || (coord_q[d] == max_coord(size_q[d]));
      carry_in[d] = c;
      c           = c & at_max[d];
      if (in_use[d] && carry_in[d]) begin
        coord_d[d] = at_max[d] ? '0 : coord_q[d] + CoordBits'(1);
        if (!at_max[d]) begin
          step = delta[d];
        end
      end
    end
    is_last  = c;
    offset_d = is_last ? '0 : offset_q + step;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coord_q  <= '0;
      offset_q <= '0;
    end else if (cfg_fire) begin
      coord_q  <= '0;
      offset_q <= '0;
    end else if (in_fire && cfg_ok) begin
      coord_q  <= coord_d;
      offset_q <= offset_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      dest_q      <= '0;
      moved_q     <= '0;
      last_q      <= 1'b0;
      status_q    <= '0;
    end else if (in_fire) begin
      out_valid_q <= 1'b1;
      dest_q      <= cfg_ok ? offset_q : '0;
      moved_q     <= s_axis_tdata[ELEMENT_BITS-1:0];
      last_q      <= cfg_ok && is_last;
      status_q    <= setup_res.status;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = OutDataBits'({moved_q, dest_q});
  assign m_axis_tlast  = last_q;
  assign m_axis_tuser  = status_q;

endmodule

### hdl/tapa_setup.sv
// ----------------------------------------------------------------------------
// Tensor axis permute addresser setup sequencer
// Checks the configuration and works out target strides and the offset step
// of each axis with one shared multiplier, one operation per cycle.
// ----------------------------------------------------------------------------
module tapa_setup #(
  parameter int unsigned INDEX_BITS = tapa_pkg::IndexBitsDef
) (
  input  logic                                          clk_i,
  input  logic                                          rst_ni,
  input  logic                                          start_i,
  input  logic [tapa_pkg::RankBits-1:0]                 rank_i,
  input  tapa_pkg::size_arr_t                           sizes_i,
  input  logic [tapa_pkg::OrderBits-1:0]                order_i,
  output tapa_pkg::setup_res_t                          res_o,
  output logic [tapa_pkg::NumAxes-1:0][INDEX_BITS-1:0]  delta_o
);
  import tapa_pkg::*;

  localparam int unsigned ProdBits = INDEX_BITS + CoordBits;

  typedef logic [NumAxes-1:0][INDEX_BITS-1:0] idx_arr_t;

  setup_state_e          state_q, state_d;
  logic [AxisBits-1:0]   pos_q, pos_d;
  logic [INDEX_BITS-1:0] acc_q, acc_d;
  logic                  ovf_q, ovf_d;
  logic [ProdBits-1:0]   prod_q, prod_d;
  logic [INDEX_BITS-1:0] span_q, span_d;
  idx_arr_t              stride_q, stride_d;
  idx_arr_t              delta_q, delta_d;
  status_e               status_q, status_d;
  logic [AxisBits-1:0]   ax;
  logic [INDEX_BITS-1:0] mul_a;
  logic [CoordBits-1:0]  mul_b;
  logic [ProdBits-1:0]   mul_p;

  function automatic status_e check_cfg(logic [RankBits-1:0] rank,
                                        logic [OrderBits-1:0] order);
    logic                range_err;
    logic                dup_err;
    logic [NumAxes-1:0]  seen;
    logic [AxisBits-1:0] f;
    range_err = 1'b0;
    dup_err   = 1'b0;
    seen      = '0;
    if (rank == '0) begin
      return ST_ZERO_RANK;
    end
    if (int'(rank) > NumAxes || int'(rank) > MaxRank) begin
      return ST_AXIS_RANGE;
    end
    for (int p = 0; p < NumAxes; p++) begin
      f = order[p*AxisBits +: AxisBits];
      if (p < int'(rank) && RankBits'(f) >= rank) begin
        range_err = 1'b1;
      end
    end
    for (int p = 0; p < NumAxes; p++) begin
      f = order[p*AxisBits +: AxisBits];
      if (p < int'(rank)) begin
        if (seen[f]) begin
          dup_err = 1'b1;
        end
        seen[f] = 1'b1;
      end
    end
    if (range_err) begin
      return ST_AXIS_RANGE;
    end
    if (dup_err) begin
      return ST_DUP_AXIS;
    end
    return ST_OK;
  endfunction

  assign ax    = order_i[pos_q*AxisBits +: AxisBits];
  assign mul_p = {{CoordBits{1'b0}}, mul_a} * {{INDEX_BITS{1'b0}}, mul_b};

  always_comb begin
    state_d  = state_q;
    pos_d    = pos_q;
    acc_d    = acc_q;
    ovf_d    = ovf_q;
    prod_d   = prod_q;
    span_d   = span_q;
    stride_d = stride_q;
    delta_d  = delta_q;
    status_d = status_q;
    mul_a    = '0;
    mul_b    = '0;
    case (state_q)
      SU_IDLE: begin
      end
      SU_CHECK: begin
        status_d = check_cfg(rank_i, order_i);
        if (status_d == ST_OK) begin
          pos_d   = AxisBits'(rank_i - RankBits'(1));
          acc_d   = INDEX_BITS'(1);
          ovf_d   = 1'b0;
          span_d  = '0;
          state_d = SU_STRIDE_MUL;
        end else begin
          state_d = SU_IDLE;
        end
      end
      SU_STRIDE_MUL: begin
        stride_d[ax] = acc_q;
        mul_a        = acc_q;
        mul_b        = eff_size(sizes_i[ax]);
        prod_d       = mul_p;
        state_d      = SU_STRIDE_ACC;
      end
      SU_STRIDE_ACC: begin
        acc_d = prod_q[INDEX_BITS-1:0];
        ovf_d = ovf_q | (|prod_q[ProdBits-1:INDEX_BITS]);
        if (pos_q == '0) begin
          if (ovf_d) begin
            status_d = ST_TOO_MANY;
            state_d  = SU_IDLE;
          end else begin
            pos_d   = AxisBits'(rank_i - RankBits'(1));
            state_d = SU_SPAN_MUL;
          end
        end else begin
          pos_d   = pos_q - AxisBits'(1);
          state_d = SU_STRIDE_MUL;
        end
      end
      SU_SPAN_MUL: begin
        delta_d[pos_q] = stride_q[pos_q] - span_q;
        mul_a          = stride_q[pos_q];
        mul_b          = max_coord(sizes_i[pos_q]);
        prod_d         = mul_p;
        state_d        = SU_SPAN_ADD;
      end
      SU_SPAN_ADD: begin
        span_d = span_q + prod_q[INDEX_BITS-1:0];
        if (pos_q == '0) begin
          state_d = SU_IDLE;
        end else begin
          pos_d   = pos_q - AxisBits'(1);
          state_d = SU_SPAN_MUL;
        end
      end
      default: begin
        state_d = SU_IDLE;
      end
    endcase
    if (start_i) begin
      state_d = SU_CHECK;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= SU_IDLE;
      pos_q    <= '0;
      acc_q    <= '0;
      ovf_q    <= 1'b0;
      prod_q   <= '0;
      span_q   <= '0;
      stride_q <= {{(NumAxes-1){INDEX_BITS'(0)}}, INDEX_BITS'(1)};
      delta_q  <= {{(NumAxes-1){INDEX_BITS'(0)}}, INDEX_BITS'(1)};
      status_q <= ST_OK;
    end else begin
      state_q  <= state_d;
      pos_q    <= pos_d;
      acc_q    <= acc_d;
      ovf_q    <= ovf_d;
      prod_q   <= prod_d;
      span_q   <= span_d;
      stride_q <= stride_d;
      delta_q  <= delta_d;
      status_q <= status_d;
    end
  end

  assign res_o.busy   = (state_q != SU_IDLE);
  assign res_o.status = status_q;
  assign delta_o      = delta_q;

endmodule
